@@ sv/nll_pkg.sv @@
// Shared types and constants for the nonlinear ladder lowpass.
package nll_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned VOLT_W   = 32;
  localparam int unsigned COEF_W   = 24;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned OSF_W    = 4;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned ADDR_W   = 5;

  localparam logic [ADDR_W-1:0] REG_STEP  = 5'd0;
  localparam logic [ADDR_W-1:0] REG_GAIN  = 5'd4;
  localparam logic [ADDR_W-1:0] REG_RES   = 5'd8;
  localparam logic [ADDR_W-1:0] REG_THERM = 5'd12;
  localparam logic [ADDR_W-1:0] REG_OSF   = 5'd16;

  // Q.28 constants for the rational tanh approximation
  localparam logic [35:0] ONE_Q28   = 36'h0_1000_0000;
  localparam logic [35:0] THREE_Q28 = 36'h0_3000_0000;
  localparam logic [35:0] K27_Q28   = 36'h1_B000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,    // wait for an input transfer
    ST_TA,      // tanh argument of the current operand
    ST_TB,      // fold the finished tanh into the derivative
    ST_U1,      // feedback product for the input term
    ST_DIV,     // divider busy
    ST_INT,     // integrate one stage
    ST_OUT,     // wait for the output register
    ST_TANH_SQ, // latch the argument magnitude and sign
    ST_TANH_NM  // square of the magnitude
  } state_t;

  typedef struct packed {
    logic       load_x;     // latch input sample
    logic       mul_u;      // form u from x and last stage
    logic       arg_mul;    // tanh argument product
    logic       sq_mul;     // latch tanh argument magnitude and sign
    logic       num_mul;    // m*m
    logic       div_step;   // divider load or one quotient bit
    logic       acc_tanh;   // fold the finished tanh into the derivative
    logic       integrate;  // update stage voltage and stored derivative
    logic       clear_d;    // clear derivative accumulator
    logic       out_load;   // capture output sample
  } nll_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sat;          // tanh argument magnitude at or beyond three
  } nll_sts_t;

endpackage

@@ sv/nll_datapath.sv @@
// Datapath: stage registers, multipliers, sequential divider and integrator.
module nll_datapath #(
  parameter int unsigned STAGES = 4,
  parameter int unsigned SW     = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  nll_pkg::nll_cmd_t                cmd,
  input  logic [SW-1:0]                    stage,
  input  logic                             second,
  input  logic signed [nll_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [nll_pkg::COEF_W-1:0]       step_coefficient,
  input  logic [nll_pkg::GAIN_W-1:0]       input_gain,
  input  logic [nll_pkg::GAIN_W-1:0]       resonance,
  input  logic [nll_pkg::GAIN_W-1:0]       thermal_scale,
  output nll_pkg::nll_sts_t                sts,
  output logic signed [nll_pkg::SAMPLE_W-1:0] sample_out
);
  import nll_pkg::*;

  logic signed [VOLT_W-1:0] volt [STAGES];
  logic signed [VOLT_W-1:0] dprev [STAGES];

  logic signed [SAMPLE_W-1:0] x;
  logic signed [47:0] u;        // input plus feedback, Q.28, never saturated
  logic signed [ACC_W-1:0] arg;
  logic [35:0] m;
  logic [35:0] m2;
  logic [71:0] num;
  logic [38:0] den;
  logic [71:0] rem;
  logic [35:0] quo;
  logic [6:0]  div_cnt;
  logic        neg;
  logic signed [VOLT_W+1:0] dacc;
  logic signed [VOLT_W+1:0] tanh_val;

  logic signed [47:0] operand;
  logic signed [ACC_W-1:0] arg_full;
  logic [ACC_W-1:0] arg_abs;
  logic [35:0] mag;
  logic [72:0] trial;
  logic signed [VOLT_W+1:0] dsum;
  logic signed [VOLT_W+COEF_W+2:0] prod;
  logic signed [VOLT_W+COEF_W+2:0] inc;
  logic signed [VOLT_W+COEF_W+3:0] vsum;
  logic signed [VOLT_W-1:0] vsat;
  logic signed [VOLT_W-6:0] ysh;

  // operand for the tanh argument
  always_comb begin
    if (stage == SW'(0)) begin
      operand = second ? u : 48'(volt[0]);
    end else begin
      operand = second ? 48'(volt[stage]) : 48'(volt[stage - SW'(1)]);
    end
    arg_full = 64'(operand) * $signed({1'b0, thermal_scale});
    arg_abs  = arg[ACC_W-1] ? ACC_W'(-arg) : ACC_W'(arg);
    // magnitudes of three and above all give the saturated result
    mag      = (arg_abs >= ACC_W'(THREE_Q28)) ? THREE_Q28 : arg_abs[35:0];
    trial    = {rem, num[71]} - {34'd0, den};
    tanh_val = sts.sat ? (neg ? -34'(ONE_Q28) : 34'(ONE_Q28))
                       : (neg ? -34'(quo) : 34'(quo));
    dsum     = dacc + 34'(dprev[stage]);
    prod     = 59'(dsum) * $signed({1'b0, step_coefficient});
    inc      = prod >>> COEF_W;
    vsum     = 60'(volt[stage]) + 60'(inc);
    if (vsum > 60'sh7FFF_FFFF) begin
      vsat = 32'sh7FFF_FFFF;
    end else if (vsum < -60'sh8000_0000) begin
      vsat = -32'sh8000_0000;
    end else begin
      vsat = vsum[VOLT_W-1:0];
    end
    ysh = volt[STAGES-1][VOLT_W-1:5];
  end

  assign sts.sat      = (m >= THREE_Q28);
  assign sts.div_done = (div_cnt == 7'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        volt[i]  <= '0;
        dprev[i] <= '0;
      end
      div_cnt <= '0;
    end else begin
      if (cmd.load_x) begin
        x <= sample_in;
      end
      if (cmd.mul_u) begin
        u <= ((48'(x) * $signed({1'b0, input_gain})) >>> 7)
           + ((48'(volt[STAGES-1]) * $signed({1'b0, resonance})) >>> 13);
      end
      if (cmd.arg_mul) begin
        arg <= arg_full >>> 10;
      end
      if (cmd.sq_mul) begin
        m   <= mag;
        neg <= arg[ACC_W-1];
      end
      if (cmd.num_mul) begin
        m2 <= 36'((72'(m) * 72'(m)) >> 28);
      end
      if (cmd.div_step) begin
        if (div_cnt == 7'd0) begin
          num     <= 72'(m) * 72'(K27_Q28 + m2);
          den     <= 39'(K27_Q28) + 39'(m2) * 39'd9;
          rem     <= '0;
          div_cnt <= 7'd72;
        end else begin
          if (!trial[72]) begin
            rem <= trial[71:0];
            quo <= {quo[34:0], 1'b1};
          end else begin
            rem <= {rem[70:0], num[71]};
            quo <= {quo[34:0], 1'b0};
          end
          num     <= {num[70:0], 1'b0};
          div_cnt <= div_cnt - 7'd1;
        end
      end
      if (cmd.clear_d) begin
        dacc <= '0;
      end else if (cmd.acc_tanh) begin
        // later stages add the tanh of the stage before, everything else subtracts
        if (stage != SW'(0) && !second) begin
          dacc <= dacc + tanh_val;
        end else begin
          dacc <= dacc - tanh_val;
        end
      end
      if (cmd.integrate) begin
        volt[stage]  <= vsat;
        dprev[stage] <= dacc[VOLT_W-1:0];
      end
      if (cmd.out_load) begin
        if (ysh > 27'sh7F_FFFF) begin
          sample_out <= 24'sh7F_FFFF;
        end else if (ysh < -27'sh80_0000) begin
          sample_out <= -24'sh80_0000;
        end else begin
          sample_out <= ysh[SAMPLE_W-1:0];
        end
      end
    end
  end

endmodule

@@ sv/nll_control.sv @@
// Sequencer: walks passes, stages and the two tanh terms of each stage.
module nll_control #(
  parameter int unsigned STAGES = 4,
  parameter int unsigned SW     = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  input  logic [nll_pkg::OSF_W-1:0] passes,
  input  nll_pkg::nll_sts_t       sts,
  output nll_pkg::nll_cmd_t       cmd,
  output logic [SW-1:0]           stage,
  output logic                    second
);
  import nll_pkg::*;

  state_t state, state_next;
  logic [OSF_W-1:0] pass;
  logic             last_stage;
  logic             div_started;  // first ST_DIV cycle loads the divider
  logic             out_full;
  logic             out_free;

  assign last_stage = (stage == SW'(STAGES - 1));
  assign in_stall   = (state != ST_IDLE);
  assign out_valid  = out_full;
  assign out_free   = !out_full || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_U1;
      ST_U1:      state_next = ST_TA;
      ST_TA:      state_next = ST_TANH_SQ;
      ST_TANH_SQ: state_next = ST_TANH_NM;
      ST_TANH_NM: state_next = ST_DIV;
      ST_DIV:     if (div_started && sts.div_done) state_next = ST_TB;
      ST_TB: begin
        if (!second) begin
          state_next = ST_TA;
        end else begin
          state_next = ST_INT;
        end
      end
      ST_INT: begin
        if (last_stage && pass == passes - OSF_W'(1)) begin
          state_next = ST_OUT;
        end else if (last_stage) begin
          state_next = ST_U1;
        end else begin
          state_next = ST_TA;
        end
      end
      ST_OUT:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load_x  = in_valid;
        cmd.clear_d = 1'b1;
      end
      ST_U1:      cmd.mul_u = 1'b1;
      ST_TA:      cmd.arg_mul = 1'b1;
      ST_TANH_SQ: cmd.sq_mul = 1'b1;
      ST_TANH_NM: begin
        cmd.num_mul  = 1'b1;
      end
      ST_DIV:     cmd.div_step = !div_started || !sts.div_done;
      ST_TB:      cmd.acc_tanh = 1'b1;
      ST_INT: begin
        cmd.integrate = 1'b1;
        cmd.clear_d   = 1'b1;
      end
      ST_OUT:     cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      stage       <= '0;
      second      <= 1'b0;
      pass        <= '0;
      div_started <= 1'b0;
      out_full    <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_full <= 1'b1;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
      if (state == ST_TANH_NM) begin
        div_started <= 1'b0;
      end else if (state == ST_DIV) begin
        div_started <= 1'b1;
      end
      if (state == ST_IDLE) begin
        stage  <= '0;
        second <= 1'b0;
        pass   <= '0;
      end else if (state == ST_TB) begin
        second <= !second;
      end else if (state == ST_INT) begin
        second <= 1'b0;
        if (last_stage) begin
          stage <= '0;
          pass  <= pass + OSF_W'(1);
        end else begin
          stage <= stage + SW'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("input not stalled while busy");
  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INT) |-> (pass < passes)) else $error("pass count overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
`endif

endmodule

@@ sv/nonlinear_ladder_lowpass.sv @@
// Top level: register file and the sequencer and datapath of the ladder lowpass.
//  channel  | handshake           | payload
//  input    | in_valid/in_stall   | sample_in
//  output   | out_valid/out_stall | sample_out
//  config   | APB psel/penable    | paddr, pwdata, prdata
// Per pass an item takes one feedback step, then per stage two tanh terms (argument,
// magnitude, square, 72-step divider, accumulate) and one integrate step; accepting
// the item comes first and loading the output register last.
// Reset is synchronous, clears stage voltages and derivatives and loads the register defaults.
// A result held under out_stall only delays the end of the following item.
module nonlinear_ladder_lowpass #(
  parameter int unsigned STAGES         = 4,
  parameter int unsigned MAX_OVERSAMPLE = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [nll_pkg::SAMPLE_W-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [nll_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nll_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import nll_pkg::*;

  localparam int unsigned SW = (STAGES > 1) ? $clog2(STAGES) : 1;

  logic [COEF_W-1:0] step_coefficient;
  logic [GAIN_W-1:0] input_gain, resonance, thermal_scale;
  logic [OSF_W-1:0]  oversample_factor;
  logic [OSF_W-1:0]  passes;
  nll_cmd_t cmd;
  nll_sts_t sts;
  logic [SW-1:0] stage;
  logic second;

  assign pready = 1'b1;

  always_comb begin
    if (oversample_factor == '0) begin
      passes = OSF_W'(1);
    end else if (5'(oversample_factor) > 5'(MAX_OVERSAMPLE)) begin
      passes = OSF_W'(MAX_OVERSAMPLE);
    end else begin
      passes = oversample_factor;
    end
    unique case (paddr)
      REG_STEP:  prdata = 32'(step_coefficient);
      REG_GAIN:  prdata = 32'(input_gain);
      REG_RES:   prdata = 32'(resonance);
      REG_THERM: prdata = 32'(thermal_scale);
      REG_OSF:   prdata = 32'(oversample_factor);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_coefficient  <= '0;
      input_gain        <= 16'd4096;
      resonance         <= '0;
      thermal_scale     <= 16'd1641;
      oversample_factor <= OSF_W'(1);
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        REG_STEP:  step_coefficient  <= pwdata[COEF_W-1:0];
        REG_GAIN:  input_gain        <= pwdata[GAIN_W-1:0];
        REG_RES:   resonance         <= pwdata[GAIN_W-1:0];
        REG_THERM: thermal_scale     <= pwdata[GAIN_W-1:0];
        REG_OSF:   oversample_factor <= pwdata[OSF_W-1:0];
        default: ;
      endcase
    end
  end

  nll_control #(.STAGES(STAGES), .SW(SW)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .passes, .sts, .cmd, .stage, .second
  );

  nll_datapath #(.STAGES(STAGES), .SW(SW)) u_dp (
    .clk, .rst, .cmd, .stage, .second, .sample_in,
    .step_coefficient, .input_gain, .resonance, .thermal_scale,
    .sts, .sample_out
  );

endmodule
